### sv/tlrf_pkg.sv
// ----------------------------------------------------------------------------
// tlrf_pkg
// Shared constants and types for the telnet receive filter: byte codes,
// result event codes and the word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package tlrf_pkg;

  localparam int LINE_MAX_DEF = 127;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_IP   = 8'd244;
  localparam logic [7:0] B_EOT  = 8'd4;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_LF   = 8'd10;
  localparam logic [7:0] B_NUL  = 8'd0;

  localparam logic [2:0] EV_DATA  = 3'd0;
  localparam logic [2:0] EV_OK    = 3'd1;
  localparam logic [2:0] EV_LONG  = 3'd2;
  localparam logic [2:0] EV_REPLY = 3'd3;
  localparam logic [2:0] EV_INTR  = 3'd4;

  localparam logic REFUSE_WONT = 1'b0;
  localparam logic REFUSE_DONT = 1'b1;

  typedef enum logic [2:0] {
    TK_DATA,
    TK_EOL,
    TK_REPLY,
    TK_INTR,
    TK_CLEAR
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] byte_val;
    logic       refuse;
  } tok_t;

endpackage

### sv/tlrf_front.sv
// ----------------------------------------------------------------------------
// tlrf_front
// Telnet command parser: tracks the IAC escape mode and the session state and
// turns each received byte into at most one word for the back end.
// ----------------------------------------------------------------------------
module tlrf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          cmd,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output tlrf_pkg::tok_t tok
);
  import tlrf_pkg::*;

  typedef enum logic [2:0] {
    M_DATA,
    M_IAC,
    M_DO,
    M_DONT,
    M_WILL,
    M_WONT
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  open_r, open_nxt;

  always_comb begin
    mode_nxt     = mode_r;
    open_nxt     = open_r;
    push         = 1'b0;
    tok.kind     = TK_DATA;
    tok.byte_val = rx_byte;
    tok.refuse   = REFUSE_WONT;
    if (acc) begin
      if (cmd) begin
        mode_nxt = M_DATA;
        open_nxt = 1'b1;
        push     = 1'b1;
        tok.kind = TK_CLEAR;
      end else if (open_r) begin
        mode_nxt = M_DATA;
        case (mode_r)
          M_IAC: begin
            if (rx_byte == B_IAC) begin
              push = 1'b1;
            end else if (rx_byte == B_DO) begin
              mode_nxt = M_DO;
            end else if (rx_byte == B_DONT) begin
              mode_nxt = M_DONT;
            end else if (rx_byte == B_WILL) begin
              mode_nxt = M_WILL;
            end else if (rx_byte == B_WONT) begin
              mode_nxt = M_WONT;
            end else if (rx_byte == B_IP) begin
              open_nxt     = 1'b0;
              push         = 1'b1;
              tok.kind     = TK_INTR;
              tok.byte_val = 8'd0;
            end
          end
          M_DO: begin
            push     = 1'b1;
            tok.kind = TK_REPLY;
          end
          M_WILL: begin
            push       = 1'b1;
            tok.kind   = TK_REPLY;
            tok.refuse = REFUSE_DONT;
          end
          M_DONT, M_WONT: begin
            push = 1'b0;
          end
          default: begin
            if (rx_byte == B_IAC) begin
              mode_nxt = M_IAC;
            end else if (rx_byte == B_NUL || rx_byte == B_CR) begin
              push = 1'b0;
            end else if (rx_byte == B_EOT) begin
              open_nxt     = 1'b0;
              push         = 1'b1;
              tok.kind     = TK_INTR;
              tok.byte_val = 8'd0;
            end else if (rx_byte == B_LF) begin
              push         = 1'b1;
              tok.kind     = TK_EOL;
              tok.byte_val = 8'd0;
            end else begin
              push = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_DATA;
      open_r <= 1'b1;
    end else begin
      mode_r <= mode_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

### sv/tlrf_fifo.sv
// ----------------------------------------------------------------------------
// tlrf_fifo
// Short word queue between the parser and the line tracker.
// ----------------------------------------------------------------------------
module tlrf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlrf_pkg::tok_t wr_tok,
  input  logic           pop,
  output tlrf_pkg::tok_t rd_tok,
  output logic           full,
  output logic           empty
);
  import tlrf_pkg::*;

  tok_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

### sv/tlrf_back.sv
// ----------------------------------------------------------------------------
// tlrf_back
// Line tracker: counts data bytes per line, flags overflow, reports line
// ends and drives the registered result port.
// ----------------------------------------------------------------------------
module tlrf_back #(
  parameter int LINE_MAX = tlrf_pkg::LINE_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  tlrf_pkg::tok_t q_tok,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_event_res,
  output logic [7:0]     out_byte,
  output logic           out_reply_refuse_kind
);
  import tlrf_pkg::*;

  localparam int LCW = $clog2(LINE_MAX + 1);
  localparam logic [LCW-1:0] LMAX = LCW'(LINE_MAX);

  logic [LCW-1:0] cnt_r, cnt_nxt;
  logic           long_r, long_nxt;
  logic           vld_r, vld_nxt;
  logic [2:0]     ev_r, ev_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           kind_r, kind_nxt;
  logic           load_ok;

  assign load_ok = !vld_r || !out_stall;
  assign q_pop   = !q_empty && load_ok;

  always_comb begin
    cnt_nxt  = cnt_r;
    long_nxt = long_r;
    vld_nxt  = vld_r;
    ev_nxt   = ev_r;
    byte_nxt = byte_r;
    kind_nxt = kind_r;
    if (load_ok) begin
      vld_nxt = 1'b0;
    end
    if (q_pop) begin
      vld_nxt  = 1'b1;
      byte_nxt = q_tok.byte_val;
      kind_nxt = 1'b0;
      case (q_tok.kind)
        TK_DATA: begin
          ev_nxt = EV_DATA;
          // overflow restarts the count with this byte as the first
          if (cnt_r >= LMAX) begin
            cnt_nxt  = LCW'(1);
            long_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        TK_EOL: begin
          ev_nxt   = (long_r || cnt_r >= LMAX) ? EV_LONG : EV_OK;
          cnt_nxt  = '0;
          long_nxt = 1'b0;
        end
        TK_REPLY: begin
          ev_nxt   = EV_REPLY;
          kind_nxt = q_tok.refuse;
        end
        TK_INTR: begin
          ev_nxt = EV_INTR;
        end
        TK_CLEAR: begin
          vld_nxt  = 1'b0;
          cnt_nxt  = '0;
          long_nxt = 1'b0;
        end
        default: begin
          vld_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      long_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      long_r <= long_nxt;
      vld_r  <= vld_nxt;
    end
    ev_r   <= ev_nxt;
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
  end

  assign out_valid             = vld_r;
  assign out_event_res         = ev_r;
  assign out_byte              = byte_r;
  assign out_reply_refuse_kind = kind_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LMAX)
    else $error("line count beyond limit");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_tok.kind == TK_CLEAR |=> cnt_r == '0 && !long_r && !vld_r)
    else $error("new connection did not clear line state");

  a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_tok.kind == TK_DATA |=> cnt_r != '0 && vld_r && ev_r == EV_DATA)
    else $error("data word not counted");

endmodule

### sv/telnet_receive_filter.sv
// ----------------------------------------------------------------------------
// telnet_receive_filter
// Telnet receive byte filter: IAC parsing and negotiation refusal in the
// front end, per-line counting and result output in the back end.
// ----------------------------------------------------------------------------
// a byte's result word passes through the queue and then the registered output of the line tracker
// throughput: one byte per cycle while the queue is not full (in_stall low)
// a four-word queue lets the parser keep taking bytes while a result is stalled
// reset sets parse mode to data, opens the session, clears line count, queue and output valid
module telnet_receive_filter #(
  parameter int LINE_MAX = tlrf_pkg::LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_res,
  output logic [7:0] out_byte,
  output logic       out_reply_refuse_kind
);
  import tlrf_pkg::*;

  logic acc;
  logic push;
  logic pop;
  logic full;
  logic empty;
  tok_t wr_tok;
  tok_t rd_tok;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  tlrf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .cmd     (in_cmd),
    .rx_byte (in_rx_byte),
    .push    (push),
    .tok     (wr_tok)
  );

  tlrf_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_tok (wr_tok),
    .pop    (pop),
    .rd_tok (rd_tok),
    .full   (full),
    .empty  (empty)
  );

  tlrf_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (empty),
    .q_tok                 (rd_tok),
    .q_pop                 (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_event_res         (out_event_res),
    .out_byte              (out_byte),
    .out_reply_refuse_kind (out_reply_refuse_kind)
  );

endmodule
